### rtl/core/rca_pkg.sv
// ============================================================================
// rca_pkg: shared types and constants for the rounded corner mask
// Item structs, fixed field widths, square root sizing, register indexes.
// ============================================================================
`default_nettype none

package rca_pkg;

  localparam int OffW     = 5;
  localparam int PixW     = 24;
  localparam int RadiusW  = 6;
  localparam int MagW     = 6;
  localparam int SqW      = 13;
  localparam int FracBits = 16;
  localparam int RootW    = 15;
  localparam int RemW     = RootW + 2;
  localparam int NumSteps = RootW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 24;

  // largest root possible from two offsets of at most 63
  localparam logic [RootW-1:0] RootMax  = 15'd22808;
  localparam logic [RootW-1:0] BandHalf = 15'd128;

  localparam logic [CfgIdxW-1:0] RegCornerRadius = 1'd0;
  localparam logic [CfgIdxW-1:0] RegBackground   = 1'd1;

  localparam logic [RadiusW-1:0]  RadiusReset = 6'd8;
  localparam logic [PixW-1:0]     BgReset     = 24'd0;

  typedef struct packed {
    logic [OffW-1:0] offset_x;
    logic [OffW-1:0] offset_y;
    logic [PixW-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic            write_enable;
    logic [PixW-1:0] pixel_out;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/rca_isqrt.sv
// ============================================================================
// rca_isqrt: pipelined integer square root
// One result bit per stage, 7.8 distance from a squared radius, pixel rides along.
// ============================================================================
`default_nettype none

module rca_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [rca_pkg::SqW-1:0]   in_sq,
  input  logic [rca_pkg::PixW-1:0]  in_pix,
  output logic                      out_valid,
  output logic [rca_pkg::RootW-1:0] out_root,
  output logic [rca_pkg::PixW-1:0]  out_pix
);
  import rca_pkg::*;

  localparam int RadW = 2 * RootW;

  logic             valid_r [NumSteps];
  logic [RemW-1:0]  rem_r   [NumSteps];
  logic [RootW-1:0] root_r  [NumSteps];
  logic [RadW-1:0]  rad_r   [NumSteps];
  logic [PixW-1:0]  pix_r   [NumSteps];

  for (genvar i = 0; i < NumSteps; i++) begin : g_step
    logic             v_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RadW-1:0]  rad_in;
    logic [PixW-1:0]  pix_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  rem_sub;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RadW'({in_sq, {FracBits{1'b0}}});
      assign pix_in  = in_pix;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign pix_in  = pix_r[i-1];
    end

    // bring down the next bit pair and try 4*root+1
    assign rem_sh  = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial   = {root_in[RemW-3:0], 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? rem_sub : rem_sh;
      root_r[i] <= {root_in[RootW-2:0], ge};
      rad_r[i]  <= rad_in << 2;
      pix_r[i]  <= pix_in;
    end
  end

  assign out_valid = valid_r[NumSteps-1];
  assign out_root  = root_r[NumSteps-1];
  assign out_pix   = pix_r[NumSteps-1];

`ifndef ASSERT_OFF
  a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, NumSteps))
    else $error("root valid without an entry");

  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_root <= RootMax)
    else $error("root above the largest possible distance");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rem_r[NumSteps-1] <= RemW'({out_root, 1'b0}))
    else $error("remainder exceeds twice the root");
`endif

endmodule

`default_nettype wire

### rtl/core/rounded_corner_antialias.sv
// ============================================================================
// rounded_corner_antialias: antialiased rounded corner mask
// Decides per corner pixel keep, paint background, or blend toward background.
// ============================================================================
//
//   channel  ports                          handshake
//   input    start, busy, in_item           taken when start and not busy
//   result   out_valid, out_item            one-cycle strobe, cannot be held
//   config   cfg_we, cfg_index, cfg_wdata   written when cfg_we is high
//
// one item per cycle; the result strobes once the item has passed every stage
// (offset stage, square stage, 15 square root bit stages, decide, blend)
// busy stays low: the receiver never stalls, so the pipeline always advances
// reset clears the stage valid bits and sets the registers to radius 8, black
//
`default_nettype none

module rounded_corner_antialias #(
  parameter int MAX_RADIUS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rca_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output rca_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic [rca_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rca_pkg::CfgDataW-1:0] cfg_wdata
);
  import rca_pkg::*;

  typedef enum logic [1:0] {ClsInside, ClsBand, ClsOutside} cls_t;

  localparam logic [RadiusW:0] MaxRadius = (RadiusW + 1)'(MAX_RADIUS);

  logic [RadiusW-1:0] corner_radius_r;
  logic [PixW-1:0]    background_color_r;
  logic [RadiusW-1:0] rad_eff;

  logic               in_accept;
  logic signed [7:0]  rx, ry;
  logic [MagW-1:0]    mx, my;

  logic               a_valid_r;
  logic [MagW-1:0]    a_mx_r, a_my_r;
  logic [PixW-1:0]    a_pix_r;

  logic [SqW-1:0]     sq_nxt;
  logic               b_valid_r;
  logic [SqW-1:0]     b_sq_r;
  logic [PixW-1:0]    b_pix_r;

  logic               s_valid;
  logic [RootW-1:0]   s_root;
  logic [PixW-1:0]    s_pix;

  logic [RootW-1:0]   r256, lo, hi;
  cls_t               cls_nxt;
  logic [7:0]         t_nxt;
  logic               c_valid_r;
  cls_t               c_cls_r;
  logic [7:0]         c_t_r;
  logic [PixW-1:0]    c_pix_r;

  logic [PixW-1:0]    blend;
  out_item_t          out_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;

  function automatic logic [7:0] mix(input logic [7:0] from, input logic [7:0] to,
                                     input logic [7:0] t);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] adj;
    logic signed [17:0] q;
    diff = $signed({1'b0, to}) - $signed({1'b0, from});
    prod = 18'(diff) * $signed({10'b0, t});
    // truncate toward zero
    adj  = prod[17] ? prod + 18'sd255 : prod;
    q    = adj >>> 8;
    return from + q[7:0];
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_radius_r    <= RadiusReset;
      background_color_r <= BgReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCornerRadius: corner_radius_r    <= cfg_wdata[RadiusW-1:0];
        RegBackground:   background_color_r <= cfg_wdata[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (corner_radius_r == '0) begin
      rad_eff = RadiusW'(1);
    end else if ({1'b0, corner_radius_r} > MaxRadius) begin
      rad_eff = MaxRadius[RadiusW-1:0];
    end else begin
      rad_eff = corner_radius_r;
    end
  end

  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  // offset stage
  assign rx = $signed({2'b00, rad_eff}) - 8'sd1 - $signed({3'b000, in_item.offset_x});
  assign ry = $signed({2'b00, rad_eff}) - 8'sd1 - $signed({3'b000, in_item.offset_y});
  assign mx = rx[7] ? MagW'(-rx) : rx[MagW-1:0];
  assign my = ry[7] ? MagW'(-ry) : ry[MagW-1:0];

  // square stage
  assign sq_nxt = SqW'({6'b0, a_mx_r} * {6'b0, a_mx_r}) +
                  SqW'({6'b0, a_my_r} * {6'b0, a_my_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= in_accept;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= s_valid;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_mx_r     <= mx;
    a_my_r     <= my;
    a_pix_r    <= in_item.pixel_in;
    b_sq_r     <= sq_nxt;
    b_pix_r    <= a_pix_r;
    c_cls_r    <= cls_nxt;
    c_t_r      <= t_nxt;
    c_pix_r    <= s_pix;
    out_item_r <= out_nxt;
  end

  rca_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid_r),
    .in_sq     (b_sq_r),
    .in_pix    (b_pix_r),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_pix   (s_pix)
  );

  // decide stage
  assign r256 = {1'b0, rad_eff, 8'b0};
  assign lo   = r256 - BandHalf;
  assign hi   = r256 + BandHalf;

  always_comb begin
    t_nxt = 8'(s_root - lo);
    if (s_root <= lo) begin
      cls_nxt = ClsInside;
    end else if (s_root >= hi) begin
      cls_nxt = ClsOutside;
    end else begin
      cls_nxt = ClsBand;
    end
  end

  // blend stage
  assign blend = {mix(c_pix_r[23:16], background_color_r[23:16], c_t_r),
                  mix(c_pix_r[15:8],  background_color_r[15:8],  c_t_r),
                  mix(c_pix_r[7:0],   background_color_r[7:0],   c_t_r)};

  always_comb begin
    case (c_cls_r)
      ClsInside: begin
        out_nxt.write_enable = 1'b0;
        out_nxt.pixel_out    = c_pix_r;
      end
      ClsOutside: begin
        out_nxt.write_enable = 1'b1;
        out_nxt.pixel_out    = background_color_r;
      end
      default: begin
        out_nxt.write_enable = 1'b1;
        out_nxt.pixel_out    = blend;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(c_valid_r))
    else $error("result without a decided item");

  a_band_weight: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_cls_r == ClsBand |-> c_t_r != 8'd0)
    else $error("blend weight zero in the band");

  a_keep_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.write_enable |-> $past(c_cls_r == ClsInside))
    else $error("write suppressed outside the arc");
`endif

endmodule

`default_nettype wire
